// ===== rtl/core/mks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_pkg
// Shared types, constants and the key decode table for the 4x3 key matrix
// scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int ROW_COUNT = 4;
    localparam int COL_COUNT = 3;
    localparam int KEY_COUNT = ROW_COUNT * COL_COUNT;

    // Item opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [ROW_COUNT-1:0] row_set_t;
    typedef logic [COL_COUNT-1:0] col_set_t;
    typedef logic [KEY_COUNT-1:0] switch_set_t;

    // Result of one beat, as handed from the debounce logic to the output stage
    typedef struct packed {
        logic [7:0] key_char;
        logic       key_down;
        logic       key_pending;
        logic [1:0] scan_phase;
    } mks_result_t;

    // Column lines read when the rows in row_set are driven
    function automatic col_set_t read_columns(switch_set_t sw, row_set_t row_set);
        col_set_t cols;
        cols = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (row_set[r])
            begin
                cols = cols | sw[r*COL_COUNT +: COL_COUNT];
            end
        end
        return cols;
    endfunction

    // Character for key number row*3+column
    function automatic logic [7:0] key_to_char(logic [3:0] key_idx);
        logic [7:0] ch;
        case (key_idx)
            4'd0:    ch = 8'h31;  // '1'
            4'd1:    ch = 8'h32;  // '2'
            4'd2:    ch = 8'h33;  // '3'
            4'd3:    ch = 8'h34;  // '4'
            4'd4:    ch = 8'h35;  // '5'
            4'd5:    ch = 8'h36;  // '6'
            4'd6:    ch = 8'h37;  // '7'
            4'd7:    ch = 8'h38;  // '8'
            4'd8:    ch = 8'h39;  // '9'
            4'd9:    ch = 8'h2E;  // '.'
            4'd10:   ch = 8'h30;  // '0'
            4'd11:   ch = 8'h23;  // '#'
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/mks_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mks_debounce
// Four-phase debounce state machine with the capture, confirm and decode
// logic. Updates its state on each processed beat and presents the result.
// ----------------------------------------------------------------------------
module mks_debounce
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  opcode,
    input  mks_pkg::switch_set_t  key_switches,
    output mks_pkg::mks_result_t  result
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    mks_pkg::row_set_t   rows_reg, rows_next;
    mks_pkg::col_set_t   cols_reg, cols_next;
    logic [7:0]          char_reg, char_next;
    logic                held_reg, held_next;
    logic                new_reg, new_next;

    logic                any_hit;
    logic                same_key;
    mks_pkg::row_set_t   cap_rows;
    mks_pkg::col_set_t   cap_cols;
    mks_pkg::col_set_t   row_cols;
    logic                dec_hit;
    logic [1:0]          dec_row;
    logic [1:0]          dec_col;
    logic [7:0]          out_char;

    // Hit detection against all rows and against the captured code
    assign any_hit  = |mks_pkg::read_columns(key_switches, '1);
    assign same_key = |(mks_pkg::read_columns(key_switches, rows_reg) & cols_reg);

    // Capture: the last row that reads any column wins
    always_comb
    begin
        cap_rows = rows_reg;
        cap_cols = cols_reg;
        row_cols = '0;
        for (int r = 0; r < mks_pkg::ROW_COUNT; r++) begin
            row_cols = key_switches[r*mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT];
            if (|row_cols)
            begin
                cap_rows = mks_pkg::row_set_t'(1) << r;
                cap_cols = row_cols;
            end
        end
    end

    // Decode: exactly one row and one column captured
    always_comb
    begin
        dec_row = '0;
        dec_col = '0;
        for (int r = 0; r < mks_pkg::ROW_COUNT; r++) begin
            if (rows_reg[r])
            begin
                dec_row = 2'(r);
            end
        end
        for (int c = 0; c < mks_pkg::COL_COUNT; c++) begin
            if (cols_reg[c])
            begin
                dec_col = 2'(c);
            end
        end
        dec_hit = $onehot(rows_reg) && $onehot(cols_reg);
    end

    // Next state for one beat
    always_comb
    begin
        phase_next = phase_reg;
        rows_next  = rows_reg;
        cols_next  = cols_reg;
        char_next  = char_reg;
        held_next  = held_reg;
        new_next   = new_reg;
        out_char   = 8'h00;

        if (opcode == mks_pkg::OP_READ)
        begin
            if (new_reg)
            begin
                new_next = 1'b0;
                out_char = char_reg;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (any_hit)
                    begin
                        rows_next  = cap_rows;
                        cols_next  = cap_cols;
                        phase_next = PH_CONFIRM;
                    end
                end
                PH_CONFIRM:
                begin
                    if (same_key)
                    begin
                        if (dec_hit)
                        begin
                            char_next = mks_pkg::key_to_char(
                                4'(dec_row) * 4'(mks_pkg::COL_COUNT) + 4'(dec_col));
                            held_next = 1'b1;
                            new_next  = 1'b1;
                        end
                        phase_next = PH_HELD;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_HELD:
                begin
                    if (!same_key)
                    begin
                        phase_next = PH_RELEASE;
                    end
                end
                PH_RELEASE:
                begin
                    if (same_key)
                    begin
                        phase_next = PH_HELD;
                    end
                    else
                    begin
                        held_next  = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Present values after the update
    assign result.key_char    = out_char;
    assign result.key_down    = held_next;
    assign result.key_pending = new_next;
    assign result.scan_phase  = phase_next;

    // Hold state; advance on a processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rows_reg  <= '0;
            cols_reg  <= '0;
            char_reg  <= 8'h00;
            held_reg  <= 1'b0;
            new_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            rows_reg  <= rows_next;
            cols_reg  <= cols_next;
            char_reg  <= char_next;
            held_reg  <= held_next;
            new_reg   <= new_next;
        end
    end

endmodule

// ===== rtl/core/matrix_keypad_scanner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_unit
// Debounced scanner for a 4-row by 3-column key matrix: scan ticks feed the
// debounce state machine, read beats return the pending key character.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall   | opcode, key_switches
//  out     | output    | out_valid/out_stall | key_char, key_down,
//          |           |                     | key_pending, scan_phase
//
//  One beat per cycle sustained unless out stalls; a beat's result passes
//  through the input register, then the result register.
//  The debounce state advances when the input register hands its beat to
//  the result register; the state machine update is the only loop.
//  rst_n clears both stages and the debounce state to idle.
//  Stall on out holds the result register; in_stall rises only when both
//  stages are full and the result is stalled.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [11:0] key_switches,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  key_char,
    output logic        key_down,
    output logic        key_pending,
    output logic [1:0]  scan_phase
);

    logic                  in_valid_reg;
    logic                  opcode_reg;
    mks_pkg::switch_set_t  switches_reg;
    logic                  out_valid_reg;
    mks_pkg::mks_result_t  result_reg;

    mks_pkg::mks_result_t  result;
    logic                  out_free;
    logic                  step_en;
    logic                  in_take;

    // Stage handoff
    assign out_free = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    mks_debounce u_debounce
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .opcode       (opcode_reg),
        .key_switches (switches_reg),
        .result       (result)
    );

    // Input register: load on accept, drop when handed on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg   <= opcode;
            switches_reg <= key_switches;
        end
    end

    // Result register: load on step, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign key_char    = result_reg.key_char;
    assign key_down    = result_reg.key_down;
    assign key_pending = result_reg.key_pending;
    assign scan_phase  = result_reg.scan_phase;

endmodule

// ===== sim/matrix_keypad_scanner_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_unit_test
// Self-checking bench for the 4x3 key matrix scanner. Scan and read beats go
// in through the valid/stall input channel, in random bursts. A local model
// of the debounce state machine predicts every result beat, and each result
// is checked field by field against it while the output side stalls on a
// pattern of its own. One phase holds the output off for a long stretch so
// that the scanner fills up and stalls its input.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_unit_test;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Debounce phases as seen on scan_phase
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_CONFIRM = 2'd1;
    localparam logic [1:0] PH_HELD    = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

    // Output stall patterns
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    // Characters for key number row*3+column
    localparam logic [7:0] KEY_CHARS [mks_pkg::KEY_COUNT] =
        '{"1", "2", "3", "4", "5", "6", "7", "8", "9", ".", "0", "#"};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [11:0] key_switches;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  key_char;
    logic        key_down;
    logic        key_pending;
    logic [1:0]  scan_phase;

    // Scanner state as the bench expects it
    logic [1:0]  scan_state;
    logic [3:0]  cap_rows;
    logic [2:0]  cap_cols;
    logic [7:0]  char_latched;
    logic        key_held;
    logic        char_pending;

    mks_pkg::mks_result_t keypad_results_due [$];

    int error_count;
    int cycle_count;
    int beats_sent;
    int burst_left;
    bit no_gaps;
    int stall_mode;
    int hold_off_cycles;

    matrix_keypad_scanner_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .key_switches (key_switches),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_char     (key_char),
        .key_down     (key_down),
        .key_pending  (key_pending),
        .scan_phase   (scan_phase)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Column lines read when the rows in rows are driven
    function automatic logic [2:0] cols_on_rows(logic [11:0] sw, logic [3:0] rows);
        logic [2:0] acc;
        acc = '0;
        for (int r = 0; r < mks_pkg::ROW_COUNT; r++)
        begin
            if (rows[r])
            begin
                acc = acc | sw[r*mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT];
            end
        end
        return acc;
    endfunction

    // Advance the expected scanner state by one beat and return its result
    function automatic mks_pkg::mks_result_t predict_keypad_beat(logic op,
                                                                 logic [11:0] sw);
        mks_pkg::mks_result_t res;
        logic        hit;
        int          row_i;
        int          col_i;
        res.key_char = 8'h00;
        hit = (cols_on_rows(sw, cap_rows) & cap_cols) != 3'b000;
        if (op == mks_pkg::OP_READ)
        begin
            if (char_pending)
            begin
                char_pending = 1'b0;
                res.key_char = char_latched;
            end
        end
        else
        begin
            case (scan_state)
                PH_IDLE:
                begin
                    if (sw != 12'h000)
                    begin
                        // last row with a hit wins
                        for (int r = 0; r < mks_pkg::ROW_COUNT; r++)
                        begin
                            if (sw[r*mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT] != 3'b000)
                            begin
                                cap_rows = 4'b0001 << r;
                                cap_cols = sw[r*mks_pkg::COL_COUNT +: mks_pkg::COL_COUNT];
                            end
                        end
                        scan_state = PH_CONFIRM;
                    end
                end
                PH_CONFIRM:
                begin
                    if (hit)
                    begin
                        // decode only a single row and a single column
                        row_i = -1;
                        col_i = -1;
                        for (int r = 0; r < mks_pkg::ROW_COUNT; r++)
                        begin
                            if (cap_rows == (4'b0001 << r))
                            begin
                                row_i = r;
                            end
                        end
                        for (int c = 0; c < mks_pkg::COL_COUNT; c++)
                        begin
                            if (cap_cols == (3'b001 << c))
                            begin
                                col_i = c;
                            end
                        end
                        if (row_i >= 0 && col_i >= 0)
                        begin
                            char_latched = KEY_CHARS[row_i*mks_pkg::COL_COUNT + col_i];
                            key_held     = 1'b1;
                            char_pending = 1'b1;
                        end
                        scan_state = PH_HELD;
                    end
                    else
                    begin
                        scan_state = PH_IDLE;
                    end
                end
                PH_HELD:
                begin
                    if (!hit)
                    begin
                        scan_state = PH_RELEASE;
                    end
                end
                default:
                begin
                    if (hit)
                    begin
                        scan_state = PH_HELD;
                    end
                    else
                    begin
                        key_held   = 1'b0;
                        scan_state = PH_IDLE;
                    end
                end
            endcase
        end
        res.key_down    = key_held;
        res.key_pending = char_pending;
        res.scan_phase  = scan_state;
        return res;
    endfunction

    task automatic note_error(string msg);
        if (error_count < MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            note_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
        end
    endtask

    // Send one input beat, with burst gaps, and record its expected result
    task automatic send_beat(logic op, logic [11:0] sw);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!no_gaps && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 5);
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid     = 1'b1;
        opcode       = op;
        key_switches = sw;
        do @(posedge clk); while (in_stall !== 1'b0);
        keypad_results_due.push_back(predict_keypad_beat(op, sw));
        beats_sent++;
    endtask

    task automatic send_tick(logic [11:0] sw);
        send_beat(mks_pkg::OP_TICK, sw);
        // sprinkle reads between ticks
        if ($urandom_range(0, 4) == 0)
        begin
            send_beat(mks_pkg::OP_READ, 12'($urandom));
        end
    endtask

    // Drop valid and let every expected result come out
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (keypad_results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        mks_pkg::mks_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (keypad_results_due.size() == 0)
            begin
                note_error("result beat with no expectation waiting");
            end
            else
            begin
                want = keypad_results_due.pop_front();
                check_field("key_char", want.key_char, key_char);
                check_field("key_down", want.key_down, key_down);
                check_field("key_pending", want.key_pending, key_pending);
                check_field("scan_phase", want.scan_phase, scan_phase);
            end
        end
    end

    // Output stall: a long hold-off on request, else the current pattern
    initial
    begin : out_stall_drive
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                out_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                case (stall_mode)
                    STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
                    STALL_PERIODIC: out_stall = ((cycle_count % 7) < 3);
                    default:        out_stall = 1'b0;
                endcase
            end
        end
    end

    // Extremes, every phase change and each special case
    task automatic test_directed_cases();
        stall_mode = STALL_NONE;
        send_beat(mks_pkg::OP_READ, 12'hFFF);   // read with nothing pending
        send_beat(mks_pkg::OP_TICK, 12'h000);   // idle stays idle
        send_beat(mks_pkg::OP_TICK, 12'hFFF);   // all keys: capture row 3, three columns
        send_beat(mks_pkg::OP_TICK, 12'hFFF);   // multi-column code: held, no decode
        send_beat(mks_pkg::OP_TICK, 12'h000);
        send_beat(mks_pkg::OP_TICK, 12'h000);   // two misses: back to idle
        send_beat(mks_pkg::OP_TICK, 12'h800);   // '#'
        send_beat(mks_pkg::OP_TICK, 12'h800);
        send_beat(mks_pkg::OP_READ, 12'h000);   // returns '#'
        send_beat(mks_pkg::OP_READ, 12'hFFF);   // nothing pending now
        send_beat(mks_pkg::OP_TICK, 12'h000);   // one miss ...
        send_beat(mks_pkg::OP_TICK, 12'h800);   // ... then a hit: back to held
        send_beat(mks_pkg::OP_TICK, 12'h000);
        send_beat(mks_pkg::OP_TICK, 12'h000);
        send_beat(mks_pkg::OP_TICK, 12'h001);   // '1'
        send_beat(mks_pkg::OP_TICK, 12'h002);   // other column: confirm fails
        send_beat(mks_pkg::OP_TICK, 12'h001);
        send_beat(mks_pkg::OP_TICK, 12'h008);   // other row: confirm fails
        send_beat(mks_pkg::OP_TICK, 12'h049);   // column 0 of rows 0..2: last row wins
        send_beat(mks_pkg::OP_TICK, 12'h040);   // '7'
        send_beat(mks_pkg::OP_TICK, 12'h040);
        send_beat(mks_pkg::OP_READ, 12'hFFF);
        send_beat(mks_pkg::OP_TICK, 12'h000);
        send_beat(mks_pkg::OP_TICK, 12'h000);
        drain_results();
    endtask

    // Press, hold, bounce and release sequences with random content
    task automatic test_key_sequences(int target);
        logic [11:0] press;
        int          row;
        int          style;
        int          hold;
        while (beats_sent < target)
        begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            style = $urandom_range(0, 9);
            row   = $urandom_range(0, mks_pkg::ROW_COUNT - 1);
            if (style < 6)
            begin
                press = 12'h001 << $urandom_range(0, mks_pkg::KEY_COUNT - 1);
                if ($urandom_range(0, 3) == 0)
                begin
                    press = press | (12'($urandom) & 12'($urandom) & 12'($urandom));
                end
            end
            else if (style < 8)
            begin
                press = 12'(3'($urandom_range(1, 7))) << (row * mks_pkg::COL_COUNT);
            end
            else
            begin
                press = 12'($urandom);
            end
            send_tick(press);
            if (style == 9)
            begin
                // different key on the confirm tick
                send_tick(12'($urandom));
            end
            hold = $urandom_range(1, 6);
            for (int i = 0; i < hold; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    send_tick(12'h000);   // bounce
                end
                send_tick(press);
            end
            // release, sometimes with a bounce back
            if ($urandom_range(0, 2) == 0)
            begin
                send_tick(12'h000);
                send_tick(press);
            end
            send_tick(12'h000);
            send_tick(12'h000);
            send_beat(mks_pkg::OP_READ, 12'($urandom));
        end
        drain_results();
    endtask

    // Random beats of either kind
    task automatic test_random_noise(int count);
        stall_mode = STALL_LIGHT;
        repeat (count)
        begin
            send_beat(1'($urandom), 12'($urandom));
        end
        drain_results();
    endtask

    // Hold the output off while the sender keeps going
    task automatic test_back_pressure();
        logic [11:0] press;
        no_gaps = 1'b1;
        stall_mode = STALL_HEAVY;
        hold_off_cycles = 200;
        repeat (5)
        begin
            press = 12'h001 << $urandom_range(0, mks_pkg::KEY_COUNT - 1);
            send_beat(mks_pkg::OP_TICK, press);
            send_beat(mks_pkg::OP_TICK, press);
            send_beat(mks_pkg::OP_TICK, press);
            send_beat(mks_pkg::OP_READ, 12'($urandom));
            send_beat(mks_pkg::OP_READ, 12'($urandom));
            send_beat(mks_pkg::OP_TICK, 12'h000);
            send_beat(mks_pkg::OP_TICK, 12'h000);
            send_beat(mks_pkg::OP_TICK, 12'($urandom));
        end
        no_gaps = 1'b0;
        drain_results();
    endtask

    // Main sequence
    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        opcode          = mks_pkg::OP_TICK;
        key_switches    = 12'h000;
        error_count     = 0;
        beats_sent      = 0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        stall_mode      = STALL_NONE;
        hold_off_cycles = 0;
        scan_state      = PH_IDLE;
        cap_rows        = 4'h0;
        cap_cols        = 3'h0;
        char_latched    = 8'h00;
        key_held        = 1'b0;
        char_pending    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_key_sequences(470);
        test_random_noise(40);
        test_back_pressure();

        if (keypad_results_due.size() != 0)
        begin
            note_error("expected results left over at the end");
        end
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== matrix_keypad_scanner_unit.f =====
rtl/core/mks_pkg.sv
rtl/core/mks_debounce.sv
rtl/core/matrix_keypad_scanner_unit.sv
sim/matrix_keypad_scanner_unit_test.sv
